// ----- rtl/core/bfd_pkg.sv -----
// shared constants and types for the binary frame deframer
`default_nettype none

package bfd_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int FRAME_BYTES = 2048;
  localparam int HDR_TRL     = 10;

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int LEN_W = 11;
  localparam int EV_W  = 2;

  localparam logic [7:0] SYNC_A = 8'hBA;
  localparam logic [7:0] SYNC_B = 8'hCE;

  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_FRAME = 2'd1;
  localparam logic [EV_W-1:0] EV_ERROR = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_sync_a;
    logic       is_sync_b;
  } byte_item_t;

  typedef struct packed {
    logic [EV_W-1:0]  event_res;
    logic [7:0]       msg_class;
    logic [7:0]       msg_id;
    logic [LEN_W-1:0] payload_bytes;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/bfd_front.sv -----
// input queue: accepts received bytes and tags the sync codes
`default_nettype none

module bfd_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [7:0]        in_rx_byte,
  output logic                   full,
  input  wire logic              item_take,
  output logic                   item_valid,
  output bfd_pkg::byte_item_t    item
);

  bfd_pkg::byte_item_t mem_r [2];
  logic                wptr_r;
  logic                rptr_r;
  logic [1:0]          cnt_r;
  logic                wr_en;
  logic                rd_en;
  bfd_pkg::byte_item_t wr_item;

  assign full       = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = mem_r[rptr_r];
  assign wr_en      = push && !full;
  assign rd_en      = item_take && item_valid;

  always_comb begin
    wr_item.rx_byte   = in_rx_byte;
    wr_item.is_sync_a = (in_rx_byte == bfd_pkg::SYNC_A);
    wr_item.is_sync_b = (in_rx_byte == bfd_pkg::SYNC_B);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr_r <= ~wptr_r;
      end
      if (rd_en) begin
        rptr_r <= ~rptr_r;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bfd_back.sv -----
// frame parser: sync hunt, length check, running checksum, one result per byte
`default_nettype none

module bfd_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_valid,
  input  wire bfd_pkg::byte_item_t  item,
  output logic                      item_take,
  input  wire logic                 res_full,
  output logic                      res_push,
  output bfd_pkg::result_t          res
);

  localparam int CW = bfd_pkg::CNT_W;
  localparam int LW = bfd_pkg::LEN_W;

  logic          collecting_r, collecting_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] plen_r, plen_nxt;
  logic [LW-1:0] exp_r, exp_nxt;
  logic [7:0]    class_r, class_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [7:0]    len_lo_r, len_lo_nxt;
  logic [7:0]    hdr_class_r, hdr_class_nxt;
  logic [7:0]    hdr_id_r, hdr_id_nxt;
  logic [31:0]   sum_r, sum_nxt;
  logic [31:0]   asm_r, asm_nxt;
  logic [bfd_pkg::EV_W-1:0] ev;

  logic [15:0]   len16;
  logic          len_bad;
  logic [31:0]   asm_shift;
  logic [CW-1:0] pay_end;

  assign item_take = item_valid && !res_full;
  assign res_push  = item_take;

  assign len16     = {item.rx_byte, len_lo_r};
  assign len_bad   = (len16 > 16'(bfd_pkg::MAX_PAYLOAD)) || (len16[1:0] != 2'd0);
  assign asm_shift = {item.rx_byte, asm_r[31:8]};
  assign pay_end   = CW'(plen_r) + CW'(6);

  always_comb begin
    collecting_nxt = collecting_r;
    count_nxt      = count_r;
    plen_nxt       = plen_r;
    exp_nxt        = exp_r;
    class_nxt      = class_r;
    id_nxt         = id_r;
    len_lo_nxt     = len_lo_r;
    hdr_class_nxt  = hdr_class_r;
    hdr_id_nxt     = hdr_id_r;
    sum_nxt        = sum_r;
    asm_nxt        = asm_r;
    ev             = bfd_pkg::EV_NONE;

    if (!collecting_r) begin
      if (item.is_sync_a) begin
        collecting_nxt = 1'b1;
        count_nxt      = CW'(1);
        exp_nxt        = '0;
        asm_nxt        = '0;
      end
    end else if ((count_r == CW'(1)) && !item.is_sync_b) begin
      if (!item.is_sync_a) begin
        collecting_nxt = 1'b0;
        count_nxt      = '0;
        ev             = bfd_pkg::EV_ERROR;
      end
    end else if (count_r >= CW'(bfd_pkg::FRAME_BYTES)) begin
      collecting_nxt = 1'b0;
      count_nxt      = '0;
      ev             = bfd_pkg::EV_ERROR;
    end else begin
      count_nxt = count_r + CW'(1);
      case (count_r)
        CW'(2): len_lo_nxt = item.rx_byte;
        CW'(3): begin
          plen_nxt = len16[LW-1:0];
          exp_nxt  = len16[LW-1:0] + LW'(bfd_pkg::HDR_TRL);
        end
        CW'(4): hdr_class_nxt = item.rx_byte;
        CW'(5): begin
          hdr_id_nxt = item.rx_byte;
          sum_nxt    = {item.rx_byte, hdr_class_r, 5'd0, plen_r};
        end
        default: begin
          if (count_r >= CW'(6)) begin
            asm_nxt = asm_shift;
            if ((count_r < pay_end) && (count_r[1:0] == 2'd1)) begin
              sum_nxt = sum_r + asm_shift;
            end
          end
        end
      endcase

      if ((count_r == CW'(3)) && len_bad) begin
        collecting_nxt = 1'b0;
        count_nxt      = '0;
        ev             = bfd_pkg::EV_ERROR;
      end else if ((exp_r != '0) && (count_nxt >= CW'(exp_r))) begin
        collecting_nxt = 1'b0;
        class_nxt      = hdr_class_r;
        id_nxt         = hdr_id_r;
        ev             = (asm_shift == sum_r) ? bfd_pkg::EV_FRAME : bfd_pkg::EV_ERROR;
      end
    end
  end

  always_comb begin
    res.event_res     = ev;
    res.msg_class     = class_nxt;
    res.msg_id        = id_nxt;
    res.payload_bytes = plen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      count_r      <= '0;
      plen_r       <= '0;
      exp_r        <= '0;
      class_r      <= '0;
      id_r         <= '0;
    end else if (item_take) begin
      collecting_r <= collecting_nxt;
      count_r      <= count_nxt;
      plen_r       <= plen_nxt;
      exp_r        <= exp_nxt;
      class_r      <= class_nxt;
      id_r         <= id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      len_lo_r    <= len_lo_nxt;
      hdr_class_r <= hdr_class_nxt;
      hdr_id_r    <= hdr_id_nxt;
      sum_r       <= sum_nxt;
      asm_r       <= asm_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bfd_outq.sv -----
// result queue: holds finished results until popped
`default_nettype none

module bfd_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_push,
  input  wire bfd_pkg::result_t  res,
  output logic                   res_full,
  input  wire logic              pop,
  output logic                   empty,
  output bfd_pkg::result_t       head
);

  bfd_pkg::result_t mem_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;
  logic             wr_en;
  logic             rd_en;

  assign res_full = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head     = mem_r[rptr_r];
  assign wr_en    = res_push && !res_full;
  assign rd_en    = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr_r <= ~wptr_r;
      end
      if (rd_en) begin
        rptr_r <= ~rptr_r;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/binary_frame_deframer_sum32.sv -----
// top level of the length-prefixed frame deframer with 32-bit additive checksum
// path: a byte is registered in the input queue, parsed combinationally in bfd_back,
//   and its result is registered in the result queue before it can be popped
// throughput: one byte per cycle, unless a full result queue stalls the parser step in bfd_back
// reset: synchronous active-low rst_n empties both queues and clears parser state
`default_nettype none

module binary_frame_deframer_sum32 (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [7:0]                  in_rx_byte,
  output logic                             full,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [bfd_pkg::EV_W-1:0]         out_event_res,
  output logic [7:0]                       out_msg_class,
  output logic [7:0]                       out_msg_id,
  output logic [bfd_pkg::LEN_W-1:0]        out_payload_bytes
);

  logic                item_valid;
  logic                item_take;
  bfd_pkg::byte_item_t item;
  logic                res_full;
  logic                res_push;
  bfd_pkg::result_t    res;
  bfd_pkg::result_t    head;

  bfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_rx_byte (in_rx_byte),
    .full       (full),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  bfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  bfd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign out_event_res     = head.event_res;
  assign out_msg_class     = head.msg_class;
  assign out_msg_id        = head.msg_id;
  assign out_payload_bytes = head.payload_bytes;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench for the binary frame deframer with 32-bit sum checksum
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]       data;
    logic             known;
    bfd_pkg::result_t res;
  } stim_row_t;

  localparam bfd_pkg::result_t NO_RES = '0;
  localparam int N_DIR = 23;

  // sync hunt, bad sync, bad length (odd and too long), then an empty frame with all-ones class and id
  localparam stim_row_t DIRECTED [N_DIR] = '{
    '{8'h00, 1'b1, '{bfd_pkg::EV_NONE, 8'h00, 8'h00, 11'd0}},
    '{8'hFF, 1'b1, '{bfd_pkg::EV_NONE, 8'h00, 8'h00, 11'd0}},
    '{8'hBA, 1'b1, '{bfd_pkg::EV_NONE, 8'h00, 8'h00, 11'd0}},
    '{8'hBA, 1'b0, NO_RES},
    '{8'h12, 1'b1, '{bfd_pkg::EV_ERROR, 8'h00, 8'h00, 11'd0}},
    '{8'hBA, 1'b0, NO_RES},
    '{8'hCE, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{bfd_pkg::EV_ERROR, 8'h00, 8'h00, 11'd3}},
    '{8'hBA, 1'b0, NO_RES},
    '{8'hCE, 1'b0, NO_RES},
    '{8'h04, 1'b0, NO_RES},
    '{8'h04, 1'b1, '{bfd_pkg::EV_ERROR, 8'h00, 8'h00, 11'd1028}},
    '{8'hBA, 1'b0, NO_RES},
    '{8'hCE, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{bfd_pkg::EV_FRAME, 8'hFF, 8'hFF, 11'd0}}
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      push = 1'b0;
  logic [7:0]                in_rx_byte = 8'h00;
  logic                      full;
  logic                      pop = 1'b0;
  logic                      empty;
  logic [bfd_pkg::EV_W-1:0]  out_event_res;
  logic [7:0]                out_msg_class;
  logic [7:0]                out_msg_id;
  logic [bfd_pkg::LEN_W-1:0] out_payload_bytes;

  logic             row_known = 1'b0;
  bfd_pkg::result_t row_res = '0;

  stim_row_t        stim_q[$];
  bfd_pkg::result_t expected_q[$];
  int unsigned      fail_count = 0;
  int unsigned      bytes_in = 0;
  int unsigned      frames_seen = 0;
  int unsigned      errors_seen = 0;
  int unsigned      pauses = 0;
  int unsigned      big_frames = 0;

  // parser state mirror
  bit               in_frame = 1'b0;
  int unsigned      byte_cnt = 0;
  logic [7:0]       hdr [6];
  logic [15:0]      len_field = '0;
  int unsigned      frame_end = 0;
  logic [7:0]       cls_q = '0;
  logic [7:0]       id_q = '0;
  logic [31:0]      chk_sum = '0;
  logic [31:0]      chk_word = '0;

  binary_frame_deframer_sum32 uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .in_rx_byte        (in_rx_byte),
    .full              (full),
    .pop               (pop),
    .empty             (empty),
    .out_event_res     (out_event_res),
    .out_msg_class     (out_msg_class),
    .out_msg_id        (out_msg_id),
    .out_payload_bytes (out_payload_bytes)
  );

  function automatic bfd_pkg::result_t parse_byte(input logic [7:0] b);
    bfd_pkg::result_t         r;
    logic [bfd_pkg::EV_W-1:0] ev;
    int unsigned              pos;
    ev = bfd_pkg::EV_NONE;
    if (!in_frame) begin
      if (b == bfd_pkg::SYNC_A) begin
        hdr[0] = b;
        byte_cnt = 1;
        frame_end = 0;
        chk_word = '0;
        in_frame = 1'b1;
      end
    end else if (byte_cnt == 1 && b != bfd_pkg::SYNC_B) begin
      if (b == bfd_pkg::SYNC_A) begin
        hdr[0] = b;
      end else begin
        in_frame = 1'b0;
        byte_cnt = 0;
        ev = bfd_pkg::EV_ERROR;
      end
    end else if (byte_cnt >= bfd_pkg::FRAME_BYTES) begin
      in_frame = 1'b0;
      byte_cnt = 0;
      ev = bfd_pkg::EV_ERROR;
    end else begin
      pos = byte_cnt;
      if (pos < 6) hdr[pos] = b;
      byte_cnt = pos + 1;
      if (pos == 3) begin
        len_field = {hdr[3], hdr[2]};
        if (len_field > bfd_pkg::MAX_PAYLOAD || len_field[1:0] != 2'b00) begin
          in_frame = 1'b0;
          byte_cnt = 0;
          ev = bfd_pkg::EV_ERROR;
        end else begin
          frame_end = len_field + bfd_pkg::HDR_TRL;
        end
      end else if (pos == 5) begin
        chk_sum = 32'(len_field) + {8'h00, hdr[4], 16'h0000} + {b, 24'h000000};
      end else if (pos >= 6) begin
        chk_word = {b, chk_word[31:8]};
        if (pos < 6 + len_field && ((pos - 6) % 4) == 3) chk_sum = chk_sum + chk_word;
      end
      if (ev == bfd_pkg::EV_NONE && frame_end != 0 && byte_cnt >= frame_end) begin
        in_frame = 1'b0;
        cls_q = hdr[4];
        id_q = hdr[5];
        ev = (chk_word == chk_sum) ? bfd_pkg::EV_FRAME : bfd_pkg::EV_ERROR;
      end
    end
    r.event_res = ev;
    r.msg_class = cls_q;
    r.msg_id = id_q;
    r.payload_bytes = len_field[bfd_pkg::LEN_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    stim_q.push_back('{b, 1'b0, NO_RES});
  endtask

  task automatic add_frame(input logic [15:0] len, input bit corrupt);
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [31:0] sum;
    logic [31:0] word;
    cls = 8'($urandom);
    id = 8'($urandom);
    sum = 32'(len) + {8'h00, cls, 16'h0000} + {id, 24'h000000};
    add_byte(bfd_pkg::SYNC_A);
    add_byte(bfd_pkg::SYNC_B);
    add_byte(len[7:0]);
    add_byte(len[15:8]);
    add_byte(cls);
    add_byte(id);
    for (int w = 0; w < len / 4; w++) begin
      word = $urandom;
      sum = sum + word;
      for (int k = 0; k < 4; k++) add_byte(word[8*k +: 8]);
    end
    if (corrupt) sum = sum ^ (32'd1 << $urandom_range(0, 31));
    for (int k = 0; k < 4; k++) add_byte(sum[8*k +: 8]);
  endtask

  task automatic build_traffic();
    int unsigned frame_no;
    int unsigned kind;
    logic [15:0] bad_len;
    logic [7:0]  b;
    frame_no = 0;
    foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);
    while (stim_q.size() < 1200) begin
      kind = $urandom_range(0, 99);
      if (frame_no == 5) begin
        add_frame(16'(bfd_pkg::MAX_PAYLOAD), 1'b0);
        big_frames++;
      end else begin
        if (kind < 60) begin
          add_frame(16'(4 * $urandom_range(0, 8)), 1'b0);
        end else if (kind < 70) begin
          add_frame(16'(4 * $urandom_range(0, 8)), 1'b1);
        end else if (kind < 78) begin
          bad_len = 16'($urandom_range(0, 65535));
          if (bad_len <= bfd_pkg::MAX_PAYLOAD && bad_len[1:0] == 2'b00) bad_len = bad_len + 16'd1;
          add_byte(bfd_pkg::SYNC_A);
          add_byte(bfd_pkg::SYNC_B);
          add_byte(bad_len[7:0]);
          add_byte(bad_len[15:8]);
        end else if (kind < 84) begin
          do b = 8'($urandom); while (b == bfd_pkg::SYNC_A || b == bfd_pkg::SYNC_B);
          add_byte(bfd_pkg::SYNC_A);
          add_byte(b);
        end else if (kind < 90) begin
          repeat ($urandom_range(1, 3)) add_byte(bfd_pkg::SYNC_A);
          add_frame(16'(4 * $urandom_range(0, 8)), 1'b0);
        end else begin
          repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
        end
      end
      frame_no++;
    end
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver stall pattern, cycling through four pop behaviours
  int unsigned pop_cyc = 0;
  always @(negedge clk) begin
    pop_cyc <= pop_cyc + 1;
    case ((pop_cyc / 97) % 4)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 2) != 0);
      2: pop <= ((pop_cyc % 5) == 0);
      default: pop <= 1'($urandom);
    endcase
  end

  always @(posedge clk) begin : monitor
    bfd_pkg::result_t pred;
    bfd_pkg::result_t want;
    if (rst_n) begin
      if (push && !full) begin
        pred = parse_byte(in_rx_byte);
        expected_q.push_back(row_known ? row_res : pred);
        bytes_in++;
      end
      if (pop && !empty) begin
        if (out_event_res == bfd_pkg::EV_FRAME) frames_seen++;
        if (out_event_res == bfd_pkg::EV_ERROR) errors_seen++;
        if (expected_q.size() == 0) begin
          $error("result transaction with no byte pending");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("event_res", 32'(want.event_res), 32'(out_event_res));
          check_field("msg_class", 32'(want.msg_class), 32'(out_msg_class));
          check_field("msg_id", 32'(want.msg_id), 32'(out_msg_id));
          check_field("payload_bytes", 32'(want.payload_bytes), 32'(out_payload_bytes));
        end
      end
    end
  end

  initial begin : sender
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    build_traffic();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < stim_q.size(); i++) begin
      // drain everything before moving on
      if (i == N_DIR || (i % 700) == 699) begin
        @(negedge clk);
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        pauses++;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          @(negedge clk);
          push <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
      @(negedge clk);
      push <= 1'b1;
      in_rx_byte <= stim_q[i].data;
      row_known <= stim_q[i].known;
      row_res <= stim_q[i].res;
      do @(posedge clk); while (full);
    end
    @(negedge clk);
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("sent %0d bytes incl. %0d max-length frames; %0d drain pauses",
             bytes_in, big_frames, pauses);
    $display("observed %0d good frames and %0d error events", frames_seen, errors_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/bfd_pkg.sv
rtl/core/bfd_front.sv
rtl/core/bfd_back.sv
rtl/core/bfd_outq.sv
rtl/core/binary_frame_deframer_sum32.sv
bench/testbench.sv
